// ----- hw/rtl/maes_pkg.sv -----
// Mini-AES package: S-box tables, GF(2^4) helpers, key schedule and round functions.
// Self-contained; imported by mini_aes_block_cipher.
package maes_pkg;

  localparam int BlockW = 16;
  localparam int KeyW   = 16;
  localparam int ApbW   = 32;
  localparam int AddrW  = 3;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [3:0]        nibble_t;

  // Operation codes on the op field
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Register index of the master key
  localparam logic REG_CIPHER_KEY = 1'b0;

  // Round constants of the key schedule
  localparam nibble_t RCON1 = 4'h1;
  localparam nibble_t RCON2 = 4'h2;

  localparam nibble_t SBOX_FWD [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };
  localparam nibble_t SBOX_INV [16] = '{
    4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
    4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
  };

  function automatic block_t nib_sub_fwd(input block_t v);
    block_t r;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = SBOX_FWD[v[4*i +: 4]];
    end
    return r;
  endfunction

  function automatic block_t nib_sub_inv(input block_t v);
    block_t r;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = SBOX_INV[v[4*i +: 4]];
    end
    return r;
  endfunction

  // Swap nibbles n1 and n3
  function automatic block_t shift_row(input block_t v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  // Multiply by x modulo x^4 + x + 1
  function automatic nibble_t gf_mul2(input nibble_t a);
    return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic nibble_t gf_mul3(input nibble_t a);
    return gf_mul2(a) ^ a;
  endfunction

  function automatic block_t mix_col(input block_t v);
    nibble_t a0;
    nibble_t a1;
    nibble_t a2;
    nibble_t a3;
    a0 = v[15:12];
    a1 = v[11:8];
    a2 = v[7:4];
    a3 = v[3:0];
    return {gf_mul3(a0) ^ gf_mul2(a1), gf_mul2(a0) ^ gf_mul3(a1),
            gf_mul3(a2) ^ gf_mul2(a3), gf_mul2(a2) ^ gf_mul3(a3)};
  endfunction

  function automatic block_t next_round_key(input block_t k, input nibble_t rcon);
    nibble_t n0;
    nibble_t n1;
    nibble_t n2;
    nibble_t n3;
    n0 = k[15:12] ^ SBOX_FWD[k[3:0]] ^ rcon;
    n1 = k[11:8] ^ n0;
    n2 = k[7:4] ^ n1;
    n3 = k[3:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic block_t encrypt(input block_t b, input block_t k0,
                                     input block_t k1, input block_t k2);
    block_t t;
    t = b ^ k0;
    t = mix_col(shift_row(nib_sub_fwd(t))) ^ k1;
    return shift_row(nib_sub_fwd(t)) ^ k2;
  endfunction

  function automatic block_t decrypt(input block_t b, input block_t k0,
                                     input block_t k1, input block_t k2);
    block_t t;
    t = b ^ k2;
    t = nib_sub_inv(shift_row(t)) ^ k1;
    t = mix_col(t);
    return nib_sub_inv(shift_row(t)) ^ k0;
  endfunction

endpackage

// ----- hw/rtl/mini_aes_block_cipher.sv -----
// Mini-AES block cipher top level: APB key register, input stage and result stage.
// Depends on maes_pkg for the S-boxes, key schedule and round functions.
//
// Usage:
//   Input channel (data_valid / data_stall): one item is an op bit and a 16-bit
//   data_block; op selects encrypt or decrypt. The item is taken at a rising
//   edge with data_valid high and data_stall low.
//   Result channel (result_valid / result_stall): one 16-bit result_block per
//   item, in order, taken at an edge with result_valid high and result_stall low.
//   Configuration: APB register 0 (byte address 0) holds the 16-bit master key.
//   Both round keys are derived and stored when the key is written, so the
//   cipher path sees only registered keys. Write the key only while idle.
// Timing:
//   An accepted item lands in the input register, then both rounds run through
//   one pass of combinational logic into the result register. Throughput is one
//   item per cycle while result_stall is low.
// Reset (rst, synchronous): both stages empty, key cleared to zero and the
//   round keys set to those of the zero key.
// Stall: when result_stall holds a waiting result, the input register still
//   takes one more item; data_stall rises only once both stages are full.
module mini_aes_block_cipher (
  input  logic                      clk,
  input  logic                      rst,
  // APB configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [maes_pkg::AddrW-1:0] paddr,
  input  logic [maes_pkg::ApbW-1:0]  pwdata,
  output logic [maes_pkg::ApbW-1:0]  prdata,
  output logic                      pready,
  // input channel
  input  logic                      data_valid,
  output logic                      data_stall,
  input  logic                      op,
  input  logic [15:0]               data_block,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [15:0]               result_block
);
  import maes_pkg::*;

  // Key registers: master key plus the two derived round keys
  block_t cipher_key;
  block_t round_key1;
  block_t round_key2;
  block_t round_key1_next;
  block_t round_key2_next;
  logic   cfg_write;

  // Input stage
  logic   stage_valid;
  logic   stage_op;
  block_t stage_block;

  // Handshake between stages
  logic   out_ready;
  logic   stage_ready;
  block_t cipher_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CIPHER_KEY);
  assign prdata    = (paddr[2] == REG_CIPHER_KEY) ?
                     {{(ApbW-KeyW){1'b0}}, cipher_key} : '0;

  // Derive the round keys from the incoming key during the write
  assign round_key1_next = next_round_key(pwdata[KeyW-1:0], RCON1);
  assign round_key2_next = next_round_key(round_key1_next, RCON2);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      round_key1 <= next_round_key('0, RCON1);
      round_key2 <= next_round_key(next_round_key('0, RCON1), RCON2);
    end else if (cfg_write) begin
      cipher_key <= pwdata[KeyW-1:0];
      round_key1 <= round_key1_next;
      round_key2 <= round_key2_next;
    end
  end

  // Result register advances when empty or being taken; input stage
  // advances when empty or when it can drain into the result register.
  assign out_ready   = !result_valid || !result_stall;
  assign stage_ready = !stage_valid || out_ready;
  assign data_stall  = !stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= data_valid;
    end
  end

  // Capture payload only on an accepted item
  always_ff @(posedge clk) begin
    if (data_valid && stage_ready) begin
      stage_op    <= op;
      stage_block <= data_block;
    end
  end

  // Both rounds in one pass
  assign cipher_out = (stage_op == OP_DECRYPT) ?
                      decrypt(stage_block, cipher_key, round_key1, round_key2) :
                      encrypt(stage_block, cipher_key, round_key1, round_key2);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= stage_valid;
    end
  end

  // Load a new result only when one moves out of the input stage
  always_ff @(posedge clk) begin
    if (out_ready && stage_valid) begin
      result_block <= cipher_out;
    end
  end

  // An occupied input stage moves into the result register whenever it can
  a_stage_drains : assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_ready |=> result_valid)
    else $error("input stage item not moved to result register");

  // Stored round keys always match the schedule of the stored key
  a_key_sched : assert property (@(posedge clk) disable iff (rst)
    round_key1 == next_round_key(cipher_key, RCON1) &&
    round_key2 == next_round_key(round_key1, RCON2))
    else $error("round keys out of step with cipher_key");

  // Input stalls only when both stages hold items
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    data_stall |-> stage_valid && result_valid && result_stall)
    else $error("input stalled with room in the pipeline");

endmodule

// ----- verif/tb_mini_aes_block_cipher.sv -----
// Self-checking testbench for mini_aes_block_cipher: directed and random items
// through both channels, checked against an in-bench cipher predictor.
// Depends on maes_pkg for block/nibble types, widths and op codes.
`timescale 1ns / 1ps

module tb_mini_aes_block_cipher;
  import maes_pkg::*;

  // Run sizing
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 130;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES    = 60;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 20;

  // Register map: the key sits at index 0, the next index is unmapped
  localparam int KEY_IDX   = int'(REG_CIPHER_KEY);
  localparam int SPARE_IDX = KEY_IDX + 1;

  // S-box tables packed with entry 0 in the low nibble
  localparam logic [63:0] FWD_SBOX_TBL = 64'h7095_C6A3_8BF2_1D4E;
  localparam logic [63:0] INV_SBOX_TBL = 64'h502B_69D7_FAC1_843E;
  localparam bit FORWARD = 1'b0;
  localparam bit INVERSE = 1'b1;
  localparam nibble_t ROUND1_CONST = 4'h1;
  localparam nibble_t ROUND2_CONST = 4'h2;

  localparam block_t EDGE_BLOCKS [6] = '{16'h0000, 16'hFFFF, 16'h8000,
                                         16'h0001, 16'hA5A5, 16'h5A5A};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  // Expected-result store plus a bit-exact model of the cipher
  class cipher_scoreboard;
    block_t master_key;
    block_t expected_blocks [$];
    int     mismatches;
    int     enc_count;
    int     dec_count;
    int     result_count;

    function new();
      master_key   = '0;
      mismatches   = 0;
      enc_count    = 0;
      dec_count    = 0;
      result_count = 0;
    endfunction

    function void load_key(block_t k);
      master_key = k;
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    function nibble_t sbox(nibble_t n, bit dir);
      return (dir == INVERSE) ? INV_SBOX_TBL[4*n +: 4] : FWD_SBOX_TBL[4*n +: 4];
    endfunction

    function block_t sub_nibbles(block_t v, bit dir);
      block_t r;
      for (int i = 0; i < 16; i += 4) r[i +: 4] = sbox(v[i +: 4], dir);
      return r;
    endfunction

    // Exchange the second and fourth nibble
    function block_t swap_row(block_t v);
      block_t r;
      r = v;
      r[11:8] = v[3:0];
      r[3:0]  = v[11:8];
      return r;
    endfunction

    function nibble_t gf_times2(nibble_t a);
      logic [4:0] t;
      t = {a, 1'b0};
      if (t[4]) t = t ^ 5'h13;
      return t[3:0];
    endfunction

    function nibble_t gf_times3(nibble_t a);
      return gf_times2(a) ^ a;
    endfunction

    function block_t mix_columns(block_t v);
      block_t r;
      r[15:12] = gf_times3(v[15:12]) ^ gf_times2(v[11:8]);
      r[11:8]  = gf_times2(v[15:12]) ^ gf_times3(v[11:8]);
      r[7:4]   = gf_times3(v[7:4])   ^ gf_times2(v[3:0]);
      r[3:0]   = gf_times2(v[7:4])   ^ gf_times3(v[3:0]);
      return r;
    endfunction

    function block_t expand_key(block_t k, nibble_t rcon);
      nibble_t w [4];
      w[0] = k[15:12] ^ sbox(k[3:0], FORWARD) ^ rcon;
      w[1] = k[11:8] ^ w[0];
      w[2] = k[7:4] ^ w[1];
      w[3] = k[3:0] ^ w[2];
      return {w[0], w[1], w[2], w[3]};
    endfunction

    function block_t cipher(logic opc, block_t blk);
      block_t k1;
      block_t k2;
      block_t t;
      k1 = expand_key(master_key, ROUND1_CONST);
      k2 = expand_key(k1, ROUND2_CONST);
      if (opc == OP_ENCRYPT) begin
        t = blk ^ master_key;
        t = mix_columns(swap_row(sub_nibbles(t, FORWARD))) ^ k1;
        t = swap_row(sub_nibbles(t, FORWARD)) ^ k2;
      end else begin
        t = blk ^ k2;
        t = sub_nibbles(swap_row(t), INVERSE) ^ k1;
        t = mix_columns(t);
        t = sub_nibbles(swap_row(t), INVERSE) ^ master_key;
      end
      return t;
    endfunction

    function void note_input(logic opc, block_t blk);
      if (opc == OP_ENCRYPT) enc_count++;
      else dec_count++;
      expected_blocks.insert(expected_blocks.size(), cipher(opc, blk));
    endfunction

    function void check_result(block_t got);
      block_t want;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result_block %h arrived with nothing expected", $time, got);
      end else begin
        want = expected_blocks.pop_front();
        result_count++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result_block mismatch, expected %h, actual %h",
                     $time, want, got);
        end
      end
    endfunction
  endclass

  // Every input starts at a known value
  logic                clk;
  logic                rst          = 1'b1;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [AddrW-1:0]    paddr        = '0;
  logic [ApbW-1:0]     pwdata       = '0;
  logic [ApbW-1:0]     prdata;
  logic                pready;
  logic                data_valid   = 1'b0;
  logic                data_stall;
  logic                op           = OP_ENCRYPT;
  logic [15:0]         data_block   = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [15:0]         result_block;

  cipher_scoreboard sb = new();

  int          cycle_count    = 0;
  int          cfg_errors     = 0;
  int          key_writes     = 0;
  int          in_stall_count = 0;
  int          hold_asked     = 0;
  int          hold_done      = 0;
  int          hold_left      = 0;
  int          mode_left      = 0;
  stall_mode_e stall_mode     = STALL_NONE;

  mini_aes_block_cipher dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a run that stops making progress ends here as a failure
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, sb.pending());
    $display("tb_mini_aes_block_cipher: errors");
    $finish;
  end

  // Monitor: sample both channels on the pre-edge values, which is exactly what
  // the block sees at this edge, so no ordering within the step matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (data_valid && !data_stall) sb.note_input(op, data_block);
      if (data_valid && data_stall) in_stall_count++;
      if (result_valid && !result_stall) sb.check_result(result_block);
    end
  end

  // Receiver: stall on a random mode that is re-picked when its run ends. A hold-off
  // request from the stimulus side pins stall high for HOLD_CYCLES so the
  // pipeline fills and pushes back on the input.
  always @(posedge clk) begin
    logic stall_next;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (hold_done != hold_asked) begin
      hold_done++;
      hold_left  = HOLD_CYCLES - 1;
      stall_next = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  stall_next = 1'b0;
        STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
        default:     stall_next = ~result_stall;
      endcase
    end
    result_stall <= stall_next;
  end

  // Offer one item and hold it until the block takes it.
  // Entered and left right after a rising edge.
  task automatic send_block(input logic opc, input block_t blk);
    data_valid <= 1'b1;
    op         <= opc;
    data_block <= blk;
    @(posedge clk);
    while (data_stall) @(posedge clk);
  endtask

  // Mostly random blocks, with all-zero, all-one, one-hot and one-cold patterns mixed in
  function automatic block_t pick_block();
    block_t one_hot;
    one_hot = block_t'(1) << $urandom_range(0, 15);
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return block_t'($urandom);
    endcase
  endfunction

  // Send items in bursts of random length; a gap limit of zero sends solid
  task automatic run_traffic(input int n_items, input int gap_max);
    int   left;
    int   burst;
    int   gap;
    logic opc;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        opc = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
        send_block(opc, pick_block());
      end
      left -= burst;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0 && left > 0) begin
        data_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every expected result has come back. The first
  // edge lets the monitor note an item taken at the edge we were called on.
  task automatic drain();
    data_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [AddrW-1:0] reg_addr(input int idx);
    return AddrW'(idx * 4);
  endfunction

  // APB write: setup, access, then an idle phase before the next transfer
  task automatic write_reg(input int idx, input logic [ApbW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // only the key register exists; the upper data bits are ignored
    if (idx == KEY_IDX) begin
      sb.load_key(value[KeyW-1:0]);
      key_writes++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // APB read of the key; prdata is taken on the edge that completes the access
  task automatic check_key_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(KEY_IDX);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[KeyW-1:0] !== sb.master_key) begin
      cfg_errors++;
      $display("%0t: cipher_key readback mismatch, expected %h, actual %h",
               $time, sb.master_key, prdata[KeyW-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    block_t key_val;
    int     total_errors;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: edge blocks both ways under the reset key of zero
    check_key_readback();
    foreach (EDGE_BLOCKS[i]) begin
      send_block(OP_ENCRYPT, EDGE_BLOCKS[i]);
      send_block(OP_DECRYPT, EDGE_BLOCKS[i]);
    end
    drain();

    // All-ones key; a write to the unmapped index must leave it alone
    write_reg(KEY_IDX, 32'h0000_FFFF);
    write_reg(SPARE_IDX, 32'h0000_1234);
    check_key_readback();
    send_block(OP_ENCRYPT, 16'h0000);
    send_block(OP_DECRYPT, 16'hFFFF);
    send_block(OP_ENCRYPT, 16'h1234);
    send_block(OP_DECRYPT, 16'hEDCB);
    drain();

    // Textbook key and block pair; junk in the upper write bits is dropped
    write_reg(KEY_IDX, 32'hABCD_C3F0);
    check_key_readback();
    send_block(OP_ENCRYPT, 16'h9C63);
    send_block(OP_DECRYPT, 16'h72C6);
    send_block(OP_ENCRYPT, 16'hFFFF);
    send_block(OP_DECRYPT, 16'h0000);
    drain();

    // Random phases, one key each; the first two take the key extremes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) key_val = 16'h0000;
      else if (p == 1) key_val = 16'hFFFF;
      else key_val = block_t'($urandom);
      write_reg(KEY_IDX, {16'($urandom), key_val});
      if ($urandom_range(0, 2) == 0) write_reg(SPARE_IDX, $urandom);
      check_key_readback();
      // ask the receiver for a long hold-off while items keep coming solid
      if (p == PRESSURE_PHASE) hold_asked++;
      if (p == PRESSURE_PHASE || p == 5) run_traffic(PHASE_ITEMS, 0);
      else run_traffic(PHASE_ITEMS, 2 + 3 * (p % 3));
      drain();
    end

    total_errors = sb.mismatches + cfg_errors + sb.pending();
    $display("Run covered %0d encrypt and %0d decrypt items over %0d key writes,",
             sb.enc_count, sb.dec_count, key_writes);
    $display("%0d results checked; input held off for %0d cycles under back-pressure.",
             sb.result_count, in_stall_count);
    if (total_errors == 0) begin
      $display("tb_mini_aes_block_cipher: clean");
    end else begin
      $display("tb_mini_aes_block_cipher: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/maes_pkg.sv
hw/rtl/mini_aes_block_cipher.sv
verif/tb_mini_aes_block_cipher.sv
